FILE: rtl/lru_writeback_block_cache_directory_assert.svh
// ----------------------------------------------------------------------------
// Block cache directory assertion macros
// Clocked assertions, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LRU_WRITEBACK_BLOCK_CACHE_DIRECTORY_ASSERT_SVH
`define LRU_WRITEBACK_BLOCK_CACHE_DIRECTORY_ASSERT_SVH
`define LWC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbl failed");
`define LWC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbl failed");
`endif

FILE: rtl/lwc_pkg.sv
// ----------------------------------------------------------------------------
// lwc_pkg
// Types and codes shared by the block cache directory modules.
// ----------------------------------------------------------------------------
package lwc_pkg;
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_CLOSE = 2'd3;
    localparam logic [1:0] EV_HIT   = 2'd0;
    localparam logic [1:0] EV_FETCH = 2'd1;
    localparam logic [1:0] EV_WB    = 2'd2;
    localparam logic [1:0] EV_DONE  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_VSCAN,
        S_EVICT,
        S_ADJ,
        S_FSCAN,
        S_DONE
    } t_state;
endpackage

FILE: rtl/lwc_slot_scan.sv
// ----------------------------------------------------------------------------
// lwc_slot_scan
// Shared slot compare unit: matches one slot against a key and recency.
// ----------------------------------------------------------------------------
module lwc_slot_scan import lwc_pkg::*; #(
    parameter int FW = 4,
    parameter int BW = 36,
    parameter int RW = 6
) (
    input  logic          i_valid,
    input  logic [FW-1:0] i_slot_file,
    input  logic [BW-1:0] i_slot_block,
    input  logic [RW-1:0] i_slot_rec,
    input  logic [FW-1:0] i_key_file,
    input  logic [BW-1:0] i_key_block,
    input  logic [RW-1:0] i_best_rec,
    input  logic          i_have_best,
    output logic          o_file_eq,
    output logic          o_hit,
    output logic          o_older
);
    assign o_file_eq = i_valid && (i_slot_file == i_key_file);
    assign o_hit     = o_file_eq && (i_slot_block == i_key_block);
    assign o_older   = i_valid && (!i_have_best || (i_slot_rec > i_best_rec));
endmodule

FILE: rtl/lru_writeback_block_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_directory
// Access: result in the last busy cycle; each evicted block lengthens the access.
// Flush and close: write-backs are issued during the slot scan, result in the last busy cycle.
// Synchronous reset leaves all slots invalid; results cannot be stalled.
// ----------------------------------------------------------------------------
`include "lru_writeback_block_cache_directory_assert.svh"
module lru_writeback_block_cache_directory import lwc_pkg::*; #(
    parameter int CAPACITY    = 32,
    parameter int BLOCK_BYTES = 4096,
    parameter int FILES       = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_file_id,
    input  logic [47:0] i_byte_offset,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_event_res,
    output logic [3:0]  o_out_file,
    output logic [47:0] o_block_base,
    output logic [4:0]  o_slot,
    output logic        o_last
);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OB = $clog2(BLOCK_BYTES);
    localparam int BW = 48 - OB;

    t_state          r_state, n_state;
    logic [CAPACITY-1:0] r_valid, r_dirty;
    logic [3:0]      r_sfile [CAPACITY];
    logic [BW-1:0]   r_sblk  [CAPACITY];
    logic [CW-1:0]   r_srec  [CAPACITY];
    logic [CW-1:0]   r_occ;
    logic [5:0]      r_maxb;
    logic [1:0]      r_kind;
    logic [3:0]      r_file;
    logic [BW-1:0]   r_blk;
    logic [SW-1:0]   r_idx;
    logic            r_hit, r_have;
    logic [SW-1:0]   r_hslot, r_free, r_best;
    logic [CW-1:0]   r_brec;

    logic file_eq, hit, older;
    logic [CW-1:0] lim;
    logic [3:0] key_file;
    logic at_end;

    always_comb begin
        if (r_maxb == 6'd0) lim = CW'(1);
        else if (r_maxb > 6'(CAPACITY)) lim = CW'(CAPACITY);
        else lim = CW'(r_maxb);
    end

    assign key_file = 4'(32'(i_file_id) % FILES);
    assign at_end = (r_idx == SW'(CAPACITY - 1));

    lwc_slot_scan #(.FW(4), .BW(BW), .RW(CW)) u_scan (
        .i_valid(r_valid[r_idx]), .i_slot_file(r_sfile[r_idx]),
        .i_slot_block(r_sblk[r_idx]), .i_slot_rec(r_srec[r_idx]),
        .i_key_file(r_file), .i_key_block(r_blk), .i_best_rec(r_brec),
        .i_have_best(r_have), .o_file_eq(file_eq), .o_hit(hit), .o_older(older)
    );

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // Eviction needed: on hit while occ > lim, on miss while occ >= lim.
    logic need_evict;
    assign need_evict = r_hit ? (r_occ > lim) : (r_occ >= lim);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = (i_kind[1]) ? S_FSCAN : S_SCAN;
            S_SCAN:   if (at_end || hit) n_state = S_ADJ;
            S_ADJ:    n_state = S_DECIDE;
            S_DECIDE: n_state = need_evict ? S_VSCAN : S_DONE;
            S_VSCAN:  if (at_end) n_state = S_EVICT;
            S_EVICT:  n_state = S_DECIDE;
            S_FSCAN:  if (at_end) n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_strobe = 1'b0;
        o_event_res = EV_DONE;
        o_out_file = r_file;
        o_block_base = {r_blk, OB'(0)};
        o_slot = 5'(r_hslot);
        o_last = 1'b0;
        case (r_state)
            S_EVICT: begin
                o_strobe = r_have && r_dirty[r_best];
                o_event_res = EV_WB;
                o_out_file = r_sfile[r_best];
                o_block_base = {r_sblk[r_best], OB'(0)};
                o_slot = 5'(r_best);
            end
            S_FSCAN: begin
                o_strobe = file_eq && r_dirty[r_idx];
                o_event_res = EV_WB;
                o_block_base = {r_sblk[r_idx], OB'(0)};
                o_slot = 5'(r_idx);
            end
            S_DONE: begin
                o_strobe = 1'b1;
                o_last = 1'b1;
                if (r_kind[1]) begin
                    o_event_res = EV_DONE;
                    o_block_base = '0;
                    o_slot = '0;
                end else begin
                    o_event_res = r_hit ? EV_HIT : EV_FETCH;
                    o_slot = 5'(r_hit ? r_hslot : r_free);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_dirty <= '0;
            r_occ <= '0;
            r_maxb <= 6'd32;
            r_idx <= '0;
            r_hit <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) r_maxb <= i_cfg_data;
                    if (start) begin
                        r_kind <= i_kind;
                        r_file <= key_file;
                        r_blk <= i_byte_offset[47:OB];
                        r_idx <= '0;
                        r_hit <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_hit <= 1'b1;
                        r_hslot <= r_idx;
                        r_brec <= r_srec[r_idx];
                    end
                    r_idx <= r_idx + SW'(1);
                end
                S_ADJ: begin
                    // Touch on hit; on miss all ranks age later at insert.
                    if (r_hit) begin
                        for (int i = 0; i < CAPACITY; i++)
                            if (r_valid[i] && r_srec[i] < r_brec) r_srec[i] <= r_srec[i] + CW'(1);
                        r_srec[r_hslot] <= '0;
                        if (r_kind == KIND_WRITE) r_dirty[r_hslot] <= 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    r_have <= 1'b0;
                    if (!need_evict && !r_hit) begin
                        for (int i = CAPACITY - 1; i >= 0; i--)
                            if (!r_valid[i]) r_free <= SW'(i);
                    end
                end
                S_VSCAN: begin
                    if (older) begin
                        r_have <= 1'b1;
                        r_best <= r_idx;
                        r_brec <= r_srec[r_idx];
                    end
                    r_idx <= r_idx + SW'(1);
                end
                S_EVICT: begin
                    if (!r_have) r_occ <= '0;
                    else begin
                        for (int i = 0; i < CAPACITY; i++)
                            if (r_valid[i] && r_srec[i] > r_brec) r_srec[i] <= r_srec[i] - CW'(1);
                        r_valid[r_best] <= 1'b0;
                        r_dirty[r_best] <= 1'b0;
                        r_occ <= r_occ - CW'(1);
                    end
                end
                S_FSCAN: begin
                    if (file_eq) begin
                        r_dirty[r_idx] <= 1'b0;
                        if (r_kind == KIND_CLOSE) begin
                            for (int i = 0; i < CAPACITY; i++)
                                if (i != int'(r_idx) && r_valid[i] && r_srec[i] > r_srec[r_idx])
                                    r_srec[i] <= r_srec[i] - CW'(1);
                            r_valid[r_idx] <= 1'b0;
                            if (r_occ != '0) r_occ <= r_occ - CW'(1);
                        end
                    end
                    r_idx <= r_idx + SW'(1);
                end
                S_DONE: begin
                    if (!r_kind[1] && !r_hit) begin
                        for (int i = 0; i < CAPACITY; i++)
                            if (r_valid[i]) r_srec[i] <= r_srec[i] + CW'(1);
                        r_valid[r_free] <= 1'b1;
                        r_dirty[r_free] <= (r_kind == KIND_WRITE);
                        r_sfile[r_free] <= r_file;
                        r_sblk[r_free] <= r_blk;
                        r_srec[r_free] <= '0;
                        r_occ <= r_occ + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    `LWC_ASSERT_IMPL(a_done_last, i_clk, i_rst_n, r_state == S_DONE, o_strobe && o_last)
    `LWC_ASSERT_IMPL(a_occ_cap, i_clk, i_rst_n, 1'b1, r_occ <= CW'(CAPACITY))
    `LWC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
endmodule
